// ===== hdl/alsu_pkg.sv =====
// Package for the antialiased line stepper: coordinate widths, operation codes,
// channel payload structs, controller states and controller/datapath links.
// No dependencies.
package alsu_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS_DEFAULT = 16;
  localparam int COV_BITS = 8;
  localparam logic [COV_BITS-1:0] COV_MAX = 8'd255;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef struct packed {
    logic                  operation;
    logic [COORD_BITS-1:0] first_x;
    logic [COORD_BITS-1:0] first_y;
    logic [COORD_BITS-1:0] second_x;
    logic [COORD_BITS-1:0] second_y;
  } line_cmd_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COV_BITS-1:0]   coverage;
    logic                  last_of_step;
    logic                  line_done;
  } pixel_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_PIX_LO,
    ST_PIX_HI
  } state_t;

  typedef struct packed {
    logic load;
    logic finish;
    logic advance;
    logic sel_hi;
  } ctrl_t;

  typedef struct packed {
    logic active;
    logic frac_full;
    logic frac_zero;
    logic div_busy;
  } status_t;

endpackage

// ===== hdl/alsu_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
// Self-contained; used by the stepper datapath for the per-line slope.
module alsu_div #(
  parameter int NUM_BITS = 28,
  parameter int DEN_BITS = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_BITS-1:0] numerator,
  input  logic [DEN_BITS-1:0] denominator,
  output logic                busy,
  output logic [NUM_BITS-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_BITS + 1);

  logic [CNT_W-1:0]    count;
  logic [DEN_BITS:0]   rem;
  logic [NUM_BITS-1:0] quo;
  logic [DEN_BITS-1:0] den;

  logic [DEN_BITS:0]   rem_shift;
  logic [DEN_BITS:0]   rem_next;
  logic                q_bit;

  always_comb begin
    rem_shift = {rem[DEN_BITS-1:0], quo[NUM_BITS-1]};
    q_bit = rem_shift >= {1'b0, den};
    rem_next = q_bit ? (rem_shift - {1'b0, den}) : rem_shift;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= CNT_W'(NUM_BITS);
      quo <= numerator;
      rem <= '0;
      den <= denominator;
    end else if (count != '0) begin
      count <= count - CNT_W'(1);
      rem <= rem_next;
      quo <= {quo[NUM_BITS-2:0], q_bit};
    end
  end

  assign busy = count != '0;
  assign quotient = quo;

endmodule

// ===== hdl/alsu_dp.sv =====
// Stepper datapath: endpoint ordering, line state, slope division and pixel forming.
// Depends on alsu_pkg and alsu_div.
module alsu_dp #(
  parameter int FRAC_BITS = alsu_pkg::FRAC_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  alsu_pkg::line_cmd_t cmd,
  input  alsu_pkg::ctrl_t    ctrl,
  output alsu_pkg::status_t  status,
  output alsu_pkg::pixel_t   pix
);
  import alsu_pkg::*;

  localparam int POS_W = COORD_BITS + FRAC_BITS;

  logic                  steep_mode;
  logic [POS_W-1:0]      minor_position;
  logic [POS_W-1:0]      minor_increment;
  logic [COORD_BITS-1:0] major_position;
  logic [COORD_BITS-1:0] major_limit;
  logic                  slope_neg;
  logic                  zero_len;

  logic [COORD_BITS-1:0] adx, ady;
  logic                  steep;
  logic [COORD_BITS-1:0] a_major, a_minor, b_major, b_minor;
  logic [COORD_BITS-1:0] lo_major, lo_minor, hi_major, hi_minor;
  logic [COORD_BITS-1:0] dmajor, mag;
  logic                  neg;
  logic [POS_W-1:0]      quotient;
  logic                  div_busy;

  logic [COORD_BITS-1:0] floor_minor, next_minor, sel_minor;
  logic [COV_BITS-1:0]   frac;
  logic [COORD_BITS:0]   major_plus;

  always_comb begin
    adx = (cmd.first_x > cmd.second_x) ? cmd.first_x - cmd.second_x
                                       : cmd.second_x - cmd.first_x;
    ady = (cmd.first_y > cmd.second_y) ? cmd.first_y - cmd.second_y
                                       : cmd.second_y - cmd.first_y;
    steep = adx < ady;
    a_major = steep ? cmd.first_y : cmd.first_x;
    a_minor = steep ? cmd.first_x : cmd.first_y;
    b_major = steep ? cmd.second_y : cmd.second_x;
    b_minor = steep ? cmd.second_x : cmd.second_y;
    if (a_major > b_major) begin
      lo_major = b_major;
      lo_minor = b_minor;
      hi_major = a_major;
      hi_minor = a_minor;
    end else begin
      lo_major = a_major;
      lo_minor = a_minor;
      hi_major = b_major;
      hi_minor = b_minor;
    end
    dmajor = hi_major - lo_major;
    neg = hi_minor < lo_minor;
    mag = neg ? lo_minor - hi_minor : hi_minor - lo_minor;
  end

  alsu_div #(
    .NUM_BITS(POS_W),
    .DEN_BITS(COORD_BITS)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .start(ctrl.load),
    .numerator({mag, {FRAC_BITS{1'b0}}}),
    .denominator(dmajor),
    .busy(div_busy),
    .quotient(quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      steep_mode <= 1'b0;
      minor_position <= '0;
      minor_increment <= '0;
      major_position <= '0;
      major_limit <= '0;
      slope_neg <= 1'b0;
      zero_len <= 1'b0;
    end else begin
      if (ctrl.load) begin
        steep_mode <= steep;
        minor_position <= {lo_minor, {FRAC_BITS{1'b0}}};
        minor_increment <= '0;
        major_position <= lo_major;
        major_limit <= hi_major;
        slope_neg <= neg;
        zero_len <= dmajor == '0;
      end
      if (ctrl.finish) begin
        if (zero_len) begin
          minor_increment <= '0;
        end else if (slope_neg) begin
          minor_increment <= '0 - quotient;
        end else begin
          minor_increment <= quotient;
        end
      end
      if (ctrl.advance) begin
        major_position <= major_position + COORD_BITS'(1);
        minor_position <= minor_position + minor_increment;
      end
    end
  end

  always_comb begin
    floor_minor = minor_position[POS_W-1 -: COORD_BITS];
    next_minor = floor_minor + COORD_BITS'(1);
    frac = minor_position[FRAC_BITS-1 -: COV_BITS];
    major_plus = {1'b0, major_position} + (COORD_BITS+1)'(1);
    sel_minor = ctrl.sel_hi ? next_minor : floor_minor;

    status.active = major_position < major_limit;
    status.frac_full = frac == COV_MAX;
    status.frac_zero = frac == '0;
    status.div_busy = div_busy;

    pix.pixel_x = steep_mode ? sel_minor : major_position;
    pix.pixel_y = steep_mode ? major_position : sel_minor;
    pix.coverage = ctrl.sel_hi ? frac : COV_MAX - frac;
    pix.last_of_step = ctrl.sel_hi || (frac == '0);
    pix.line_done = major_plus == {1'b0, major_limit};
  end

endmodule

// ===== hdl/alsu_ctrl.sv =====
// Stepper controller: sequences line starts, slope division and pixel transfers.
// Depends on alsu_pkg.
module alsu_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  logic              operation,
  output logic              cmd_stall,
  output logic              pix_valid,
  input  logic              pix_stall,
  input  alsu_pkg::status_t status,
  output alsu_pkg::ctrl_t   ctrl
);
  import alsu_pkg::*;

  state_t state, state_next;
  logic   cmd_take;
  logic   pix_take;

  assign cmd_take = cmd_valid && (state == ST_IDLE);
  assign pix_take = pix_valid && !pix_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_take) begin
          if (operation == OP_START) begin
            state_next = ST_DIVIDE;
          end else if (status.active) begin
            state_next = status.frac_full ? ST_PIX_HI : ST_PIX_LO;
          end
        end
      end
      ST_DIVIDE: begin
        if (!status.div_busy) begin
          state_next = ST_IDLE;
        end
      end
      ST_PIX_LO: begin
        if (pix_take) begin
          state_next = status.frac_zero ? ST_IDLE : ST_PIX_HI;
        end
      end
      ST_PIX_HI: begin
        if (pix_take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_stall = state != ST_IDLE;
    pix_valid = (state == ST_PIX_LO) || (state == ST_PIX_HI);
    ctrl.load = cmd_take && (operation == OP_START);
    ctrl.finish = (state == ST_DIVIDE) && !status.div_busy;
    ctrl.advance = pix_take &&
                   ((state == ST_PIX_HI) || ((state == ST_PIX_LO) && status.frac_zero));
    ctrl.sel_hi = state == ST_PIX_HI;
  end

endmodule

// ===== hdl/antialiased_line_stepper_unit.sv =====
// Top level of the antialiased line stepper.
// Depends on alsu_pkg, alsu_ctrl and alsu_dp.
//
// Commands arrive on the cmd channel and pixels leave on the pix channel; each
// channel transfers at a rising edge where its valid is high and its stall low.
// A start command loads two endpoints and produces no pixels. The block then
// runs a restoring divider for the slope, one quotient bit per cycle, and holds
// cmd_stall high until the division is done and the slope is stored. A step
// command produces one or two pixels, the first valid in the cycle after the
// transfer. Each pixel holds until it is transferred; the next command is taken
// in the cycle after the last pixel of the step. A step with no line position
// left produces nothing and the next command is taken in the following cycle.
// While a pixel is stalled, its payload is held and no command is taken.
// Reset clears the line state, so steps after reset produce no pixels until a
// start command is given.
module antialiased_line_stepper_unit #(
  parameter int FRAC_BITS = alsu_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  alsu_pkg::line_cmd_t cmd,
  output logic                pix_valid,
  input  logic                pix_stall,
  output alsu_pkg::pixel_t    pix
);
  import alsu_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  alsu_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .operation(cmd.operation),
    .cmd_stall(cmd_stall),
    .pix_valid(pix_valid),
    .pix_stall(pix_stall),
    .status(status),
    .ctrl(ctrl)
  );

  alsu_dp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .ctrl(ctrl),
    .status(status),
    .pix(pix)
  );

endmodule

// ===== tb/antialiased_line_stepper_unit_tb.sv =====
// Testbench for antialiased_line_stepper_unit: directed lines, a long receiver hold-off
// and random line traffic, each pixel checked against a line tracer kept in the bench.
// Depends on alsu_pkg and the antialiased_line_stepper_unit RTL.
module antialiased_line_stepper_unit_tb;
  import alsu_pkg::*;

  localparam int FRAC = FRAC_BITS_DEFAULT;
  localparam int POS_BITS = COORD_BITS + FRAC;
  localparam int MAX_COORD = (1 << COORD_BITS) - 1;
  localparam int RANDOM_ITEMS = 1800;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  line_cmd_t cmd = '0;
  logic pix_valid;
  logic pix_stall = 1'b0;
  pixel_t pix;

  logic line_steep = 1'b0;
  logic [POS_BITS-1:0] minor_pos = '0;
  logic [POS_BITS:0] minor_inc = '0;
  logic [COORD_BITS-1:0] major_pos = '0;
  logic [COORD_BITS-1:0] major_end = '0;
  pixel_t pending_pixels[$];

  int errors = 0;
  int cycles = 0;
  int useful_items = 0;
  int gap_pct = 22;
  int stall_pct = 22;
  logic hold_on = 1'b0;
  event hold_start;

  antialiased_line_stepper_unit #(
    .FRAC_BITS(FRAC)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .pix_valid(pix_valid),
    .pix_stall(pix_stall),
    .pix(pix)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic pixel_t pixel_at(input logic [COORD_BITS-1:0] minor,
                                      input logic [COV_BITS-1:0] cov, input logic done);
    pixel_t p;
    p.pixel_x = line_steep ? minor : major_pos;
    p.pixel_y = line_steep ? major_pos : minor;
    p.coverage = cov;
    p.last_of_step = 1'b0;
    p.line_done = done;
    return p;
  endfunction

  // Updates the line state for one command and queues the pixels it must produce.
  function automatic int trace_line_command(input line_cmd_t c);
    logic [COORD_BITS-1:0] a_maj, a_min, b_maj, b_min, swap, adx, ady, dmaj, mag, flo;
    logic [POS_BITS-1:0] slope;
    logic [COV_BITS-1:0] frac;
    logic neg, done, has_near, has_far;
    pixel_t near_pix, far_pix;
    if (c.operation == OP_START) begin
      adx = c.first_x > c.second_x ? c.first_x - c.second_x : c.second_x - c.first_x;
      ady = c.first_y > c.second_y ? c.first_y - c.second_y : c.second_y - c.first_y;
      line_steep = adx < ady;
      a_maj = line_steep ? c.first_y : c.first_x;
      a_min = line_steep ? c.first_x : c.first_y;
      b_maj = line_steep ? c.second_y : c.second_x;
      b_min = line_steep ? c.second_x : c.second_y;
      if (a_maj > b_maj) begin
        swap = a_maj;
        a_maj = b_maj;
        b_maj = swap;
        swap = a_min;
        a_min = b_min;
        b_min = swap;
      end
      dmaj = b_maj - a_maj;
      neg = b_min < a_min;
      mag = neg ? a_min - b_min : b_min - a_min;
      slope = (dmaj == 0) ? '0 : {mag, {FRAC{1'b0}}} / dmaj;
      minor_inc = neg ? -{1'b0, slope} : {1'b0, slope};
      minor_pos = {a_min, {FRAC{1'b0}}};
      major_pos = a_maj;
      major_end = b_maj;
      return 0;
    end
    if (major_pos >= major_end) return 0;
    flo = minor_pos[POS_BITS-1:FRAC];
    frac = minor_pos[FRAC-1 -: COV_BITS];
    done = (major_pos + 1'b1) == major_end;
    has_near = frac != COV_MAX;
    has_far = frac != '0;
    near_pix = pixel_at(flo, COV_MAX - frac, done);
    near_pix.last_of_step = !has_far;
    far_pix = pixel_at(flo + 1'b1, frac, done);
    far_pix.last_of_step = 1'b1;
    if (has_near) pending_pixels.push_back(near_pix);
    if (has_far) pending_pixels.push_back(far_pix);
    major_pos = major_pos + 1'b1;
    minor_pos = minor_pos + minor_inc[POS_BITS-1:0];
    return int'(has_near) + int'(has_far);
  endfunction

  function automatic line_cmd_t start_cmd(input int x0, input int y0, input int x1,
                                          input int y1);
    line_cmd_t c;
    c.operation = OP_START;
    c.first_x = COORD_BITS'(x0);
    c.first_y = COORD_BITS'(y0);
    c.second_x = COORD_BITS'(x1);
    c.second_y = COORD_BITS'(y1);
    return c;
  endfunction

  function automatic int near_coord(input int base, input int span);
    int v;
    v = base + int'($urandom_range(2 * span)) - span;
    if (v < 0) v = 0;
    if (v > MAX_COORD) v = MAX_COORD;
    return v;
  endfunction

  function automatic line_cmd_t random_start(input int span);
    int x0, y0;
    x0 = $urandom_range(MAX_COORD);
    y0 = $urandom_range(MAX_COORD);
    return start_cmd(x0, y0, near_coord(x0, span), near_coord(y0, span));
  endfunction

  // Step commands carry random endpoint fields, which the block must ignore.
  function automatic line_cmd_t random_step();
    line_cmd_t c;
    c = random_start(MAX_COORD);
    c.operation = OP_STEP;
    return c;
  endfunction

  task automatic send_cmd(input line_cmd_t c);
    int n;
    while ($urandom_range(99) < gap_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    n = trace_line_command(c);
    if (c.operation == OP_START || n > 0) useful_items++;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    pixel_t want;
    if (!rst && pix_valid && !pix_stall) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel, expected none, got %p", $time, pix);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("pixel_x", 32'(want.pixel_x), 32'(pix.pixel_x));
        check_field("pixel_y", 32'(want.pixel_y), 32'(pix.pixel_y));
        check_field("coverage", 32'(want.coverage), 32'(pix.coverage));
        check_field("last_of_step", 32'(want.last_of_step), 32'(pix.last_of_step));
        check_field("line_done", 32'(want.line_done), 32'(pix.line_done));
      end
    end
    pix_stall <= hold_on || ($urandom_range(99) < stall_pct);
  end

  initial begin
    forever begin
      @(hold_start);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_on <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic test_steps_without_line();
    repeat (2) send_cmd(random_step());
  endtask

  task automatic test_directed_lines();
    send_cmd(start_cmd(0, 0, MAX_COORD, 0));
    repeat (2) send_cmd(random_step());
    send_cmd(start_cmd(3, 100, 0, 105));
    repeat (6) send_cmd(random_step());
    send_cmd(start_cmd(100, 200, 100, 200));
    send_cmd(random_step());
    send_cmd(start_cmd(MAX_COORD, 0, 0, MAX_COORD));
    repeat (2) send_cmd(random_step());
    send_cmd(start_cmd(0, 0, 3, 1));
    repeat (3) send_cmd(random_step());
    send_cmd(start_cmd(0, 1, 400, 0));
    repeat (2) send_cmd(random_step());
  endtask

  // The receiver stops taking pixels while steps keep coming, so the block must stall.
  task automatic test_receiver_hold();
    send_cmd(start_cmd(0, 0, 300, 77));
    -> hold_start;
    repeat (60) send_cmd(random_step());
  endtask

  task automatic test_random_lines();
    int roll, span, remaining, steps;
    useful_items = 0;
    while (useful_items < RANDOM_ITEMS) begin
      if (useful_items >= 600 && useful_items < 900) begin
        gap_pct <= 0;
        stall_pct <= 0;
      end else begin
        gap_pct <= 22;
        stall_pct <= 22;
      end
      roll = $urandom_range(99);
      if (roll < 8) begin
        send_cmd(random_step());
      end else begin
        span = roll < 60 ? 12 : (roll < 92 ? 60 : MAX_COORD);
        send_cmd(random_start(span));
        remaining = int'(major_end) - int'(major_pos);
        steps = remaining > 40 ? $urandom_range(40, 1) : remaining + $urandom_range(2);
        if (roll < 14 && steps > 1) steps = $urandom_range(steps - 1, 1);
        repeat (steps) send_cmd(random_step());
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_steps_without_line();
    test_directed_lines();
    test_receiver_hold();
    test_random_lines();
    cmd_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
